### sv/kmlp_pkg.sv
// ----------------------------------------------------------------------------
// kmlp_pkg: shared definitions for the key macro list player
// Sizes, action and event codes, sequencer states and inter-module structs.
// ----------------------------------------------------------------------------
`default_nettype none

package kmlp_pkg;

  // Store and held-key stack sizes.
  localparam int STORE_BYTES = 128;
  localparam int HELD_DEPTH  = 8;

  // Derived widths.
  localparam int ADDR_W     = $clog2(STORE_BYTES);
  localparam int POS_W      = $clog2(STORE_BYTES + 3);
  localparam int HELD_IDX_W = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
  localparam int HELD_CNT_W = 4;

  // Configuration register indexes.
  localparam logic [7:0] CFG_IDX_END   = 8'd0;
  localparam logic [7:0] CFG_IDX_TAP   = 8'd1;
  localparam logic [7:0] CFG_IDX_PRESS = 8'd2;
  localparam logic [7:0] CFG_IDX_DELAY = 8'd3;

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_READ    = 2'd1,
    ACT_PLAY    = 2'd2,
    ACT_RELEASE = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    KIND_TAP     = 3'd0,
    KIND_PRESS   = 3'd1,
    KIND_DELAY   = 3'd2,
    KIND_RELEASE = 3'd3,
    KIND_READ    = 3'd4,
    KIND_END     = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_SKIP,
    S_SKIP_CHK,
    S_OP,
    S_HI,
    S_LO,
    S_REL,
    S_END
  } state_e;

  typedef struct packed {
    logic [7:0] end_op;
    logic [7:0] tap_op;
    logic [7:0] press_op;
    logic [7:0] delay_op;
  } opcodes_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } store_req_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    logic [15:0] push_val;
  } held_req_t;

  typedef struct packed {
    logic [HELD_CNT_W-1:0] count;
    logic                  full;
    logic                  empty;
    logic [15:0]           top;
  } held_stat_t;

endpackage

`default_nettype wire

### sv/kmlp_store.sv
// ----------------------------------------------------------------------------
// kmlp_store: macro byte store
// Byte memory with a write port and a separate registered read port. Per-byte
// valid flags make every byte read as erased (0xFF) until it is first written.
// ----------------------------------------------------------------------------
`default_nettype none

module kmlp_store (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire kmlp_pkg::store_req_t req_i,
  output logic [7:0]                rdata_o
);

  logic [7:0]                     mem [kmlp_pkg::STORE_BYTES];
  logic [kmlp_pkg::STORE_BYTES-1:0] valid_q;
  logic [7:0]                     rdata_q;
  logic                           rvalid_q;

  // Byte array: written and read in one clocked block.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  // Written flags and the flag of the byte being read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvalid_q <= valid_q[req_i.raddr];
      end
    end
  end

  // A never-written byte reads as erased memory.
  assign rdata_o = rvalid_q ? rdata_q : 8'hFF;

endmodule

`default_nettype wire

### sv/kmlp_held.sv
// ----------------------------------------------------------------------------
// kmlp_held: held-key stack
// Small LIFO of pressed key codes with a fill count; the top entry is
// always presented for release.
// ----------------------------------------------------------------------------
`default_nettype none

module kmlp_held (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire kmlp_pkg::held_req_t  req_i,
  output kmlp_pkg::held_stat_t      stat_o
);

  logic [15:0]                     entries_q [kmlp_pkg::HELD_DEPTH];
  logic [kmlp_pkg::HELD_CNT_W-1:0] count_q;
  logic [kmlp_pkg::HELD_CNT_W-1:0] count_d;
  logic [kmlp_pkg::HELD_CNT_W-1:0] count_m1;

  assign count_m1 = count_q - kmlp_pkg::HELD_CNT_W'(1);

  // Count update: push and pop are never requested together.
  always_comb begin
    count_d = count_q;
    if (req_i.push) begin
      count_d = count_q + kmlp_pkg::HELD_CNT_W'(1);
    end else if (req_i.pop) begin
      count_d = count_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Entry storage needs no reset: only entries below the count are read.
  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      entries_q[count_q[kmlp_pkg::HELD_IDX_W-1:0]] <= req_i.push_val;
    end
  end

  assign stat_o.count = count_q;
  assign stat_o.full  = (count_q == kmlp_pkg::HELD_CNT_W'(kmlp_pkg::HELD_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign stat_o.top   = entries_q[count_m1[kmlp_pkg::HELD_IDX_W-1:0]];

endmodule

`default_nettype wire

### sv/kmlp_ctrl.sv
// ----------------------------------------------------------------------------
// kmlp_ctrl: item sequencer
// Steps the store by a byte or a skipped record with a shared position adder,
// decodes records, drives the held-key stack and owns the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kmlp_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire kmlp_pkg::opcodes_t   ops_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           action_i,
  input  wire logic [7:0]           addr_i,
  input  wire logic [7:0]           byte_data_i,
  input  wire logic [7:0]           macro_number_i,
  output kmlp_pkg::store_req_t      store_req_o,
  input  wire logic [7:0]           store_rdata_i,
  output kmlp_pkg::held_req_t       held_req_o,
  input  wire kmlp_pkg::held_stat_t held_stat_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [2:0]                event_kind_o,
  output logic [15:0]               event_value_o,
  output logic                      last_o
);

  localparam int PW = kmlp_pkg::POS_W;
  localparam int AW = kmlp_pkg::ADDR_W;

  kmlp_pkg::state_e  state_q, state_d;
  logic [PW-1:0]     pos_q, pos_d;
  logic [7:0]        mcnt_q, mcnt_d;
  kmlp_pkg::kind_e   kind_q, kind_d;
  logic [7:0]        hi_q, hi_d;
  logic              addr_ok_q, addr_ok_d;

  logic              out_valid_q;
  kmlp_pkg::kind_e   out_kind_q;
  logic [15:0]       out_value_q;
  logic              out_last_q;

  logic              load;
  kmlp_pkg::kind_e   ld_kind;
  logic [15:0]       ld_value;
  logic              ld_last;

  logic [1:0]        pos_inc;
  logic [PW-1:0]     pos_sum;
  logic              slot_free;
  logic              addr_in_range;
  logic              byte_is_end;
  logic              byte_is_rec;
  logic              pos_in_store;
  logic              record_fits;
  logic              pos_next_in;

  // Byte classification; the end opcode wins over record opcodes.
  assign byte_is_end = (store_rdata_i == ops_i.end_op);
  assign byte_is_rec = (store_rdata_i == ops_i.tap_op) ||
                       (store_rdata_i == ops_i.press_op) ||
                       (store_rdata_i == ops_i.delay_op);

  // Shared position adder; skipping a whole record moves three bytes.
  assign pos_inc = (state_q == kmlp_pkg::S_SKIP_CHK && byte_is_rec && !byte_is_end) ?
                   2'd3 : 2'd1;
  assign pos_sum = pos_q + PW'(pos_inc);

  assign addr_in_range = (addr_i < 8'(kmlp_pkg::STORE_BYTES));
  assign pos_in_store  = (pos_q < PW'(kmlp_pkg::STORE_BYTES));
  assign record_fits   = (pos_q < PW'(kmlp_pkg::STORE_BYTES - 2));
  assign pos_next_in   = (pos_sum < PW'(kmlp_pkg::STORE_BYTES));
  assign slot_free     = !out_valid_q || !out_stall_i;
  assign in_stall_o    = (state_q != kmlp_pkg::S_IDLE);

  // Next state and outputs.
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    mcnt_d      = mcnt_q;
    kind_d      = kind_q;
    hi_d        = hi_q;
    addr_ok_d   = addr_ok_q;
    store_req_o = '0;
    held_req_o  = '0;
    load        = 1'b0;
    ld_kind     = kmlp_pkg::KIND_END;
    ld_value    = '0;
    ld_last     = 1'b0;

    unique case (state_q)
      kmlp_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (kmlp_pkg::action_e'(action_i))
            kmlp_pkg::ACT_WRITE: begin
              store_req_o.we    = addr_in_range;
              store_req_o.waddr = addr_i[AW-1:0];
              store_req_o.wdata = byte_data_i;
              state_d           = kmlp_pkg::S_END;
            end
            kmlp_pkg::ACT_READ: begin
              addr_ok_d         = addr_in_range;
              store_req_o.re    = addr_in_range;
              store_req_o.raddr = addr_i[AW-1:0];
              state_d           = kmlp_pkg::S_READ;
            end
            kmlp_pkg::ACT_PLAY: begin
              pos_d   = '0;
              mcnt_d  = macro_number_i;
              state_d = kmlp_pkg::S_SKIP;
            end
            kmlp_pkg::ACT_RELEASE: begin
              state_d = kmlp_pkg::S_REL;
            end
            default: begin
              state_d = kmlp_pkg::S_IDLE;
            end
          endcase
        end
      end

      kmlp_pkg::S_READ: begin
        if (slot_free) begin
          load     = 1'b1;
          ld_kind  = kmlp_pkg::KIND_READ;
          ld_value = addr_ok_q ? {8'h00, store_rdata_i} : 16'h0000;
          state_d  = kmlp_pkg::S_END;
        end
      end

      // Fetch the byte at the current position, or stop at the store end.
      kmlp_pkg::S_SKIP: begin
        if (!pos_in_store) begin
          state_d = kmlp_pkg::S_END;
        end else begin
          store_req_o.re    = 1'b1;
          store_req_o.raddr = pos_q[AW-1:0];
          state_d = (mcnt_q == 8'd0) ? kmlp_pkg::S_OP : kmlp_pkg::S_SKIP_CHK;
        end
      end

      // Skip one byte, or a whole record; an end byte closes one macro.
      kmlp_pkg::S_SKIP_CHK: begin
        pos_d = pos_sum;
        if (byte_is_end) begin
          mcnt_d = mcnt_q - 8'd1;
        end
        state_d = kmlp_pkg::S_SKIP;
      end

      // Decode an opcode byte and fetch the high value byte.
      kmlp_pkg::S_OP: begin
        if (byte_is_end || !byte_is_rec || !record_fits) begin
          state_d = kmlp_pkg::S_END;
        end else begin
          if (store_rdata_i == ops_i.tap_op) begin
            kind_d = kmlp_pkg::KIND_TAP;
          end else if (store_rdata_i == ops_i.press_op) begin
            kind_d = kmlp_pkg::KIND_PRESS;
          end else begin
            kind_d = kmlp_pkg::KIND_DELAY;
          end
          pos_d             = pos_sum;
          store_req_o.re    = 1'b1;
          store_req_o.raddr = pos_sum[AW-1:0];
          state_d           = kmlp_pkg::S_HI;
        end
      end

      kmlp_pkg::S_HI: begin
        hi_d              = store_rdata_i;
        pos_d             = pos_sum;
        store_req_o.re    = 1'b1;
        store_req_o.raddr = pos_sum[AW-1:0];
        state_d           = kmlp_pkg::S_LO;
      end

      // Emit the record event; fetch the next opcode or end at the store end.
      kmlp_pkg::S_LO: begin
        if (slot_free) begin
          load     = 1'b1;
          ld_kind  = kind_q;
          ld_value = {hi_q, store_rdata_i};
          if (kind_q == kmlp_pkg::KIND_PRESS && !held_stat_i.full) begin
            held_req_o.push     = 1'b1;
            held_req_o.push_val = {hi_q, store_rdata_i};
          end
          pos_d = pos_sum;
          if (pos_next_in) begin
            store_req_o.re    = 1'b1;
            store_req_o.raddr = pos_sum[AW-1:0];
            state_d           = kmlp_pkg::S_OP;
          end else begin
            state_d = kmlp_pkg::S_END;
          end
        end
      end

      kmlp_pkg::S_REL: begin
        if (held_stat_i.empty) begin
          state_d = kmlp_pkg::S_END;
        end else if (slot_free) begin
          load           = 1'b1;
          ld_kind        = kmlp_pkg::KIND_RELEASE;
          ld_value       = held_stat_i.top;
          held_req_o.pop = 1'b1;
        end
      end

      kmlp_pkg::S_END: begin
        if (slot_free) begin
          load    = 1'b1;
          ld_kind = kmlp_pkg::KIND_END;
          ld_last = 1'b1;
          state_d = kmlp_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = kmlp_pkg::S_IDLE;
      end
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kmlp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    mcnt_q    <= mcnt_d;
    kind_q    <= kind_d;
    hi_q      <= hi_d;
    addr_ok_q <= addr_ok_d;
  end

  // Result register: holds while the consumer stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_kind_q  <= ld_kind;
      out_value_q <= ld_value;
      out_last_q  <= ld_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = out_kind_q;
  assign event_value_o = out_value_q;
  assign last_o        = out_last_q;

  // The held count never exceeds the stack depth.
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_stat_i.count <= kmlp_pkg::HELD_CNT_W'(kmlp_pkg::HELD_DEPTH))
    else $error("held count beyond stack depth");

  // A push is only issued while the stack has room.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_req_o.push |-> !held_stat_i.full)
    else $error("push into a full held stack");

  // Value bytes are only fetched inside the store.
  a_value_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kmlp_pkg::S_HI || state_q == kmlp_pkg::S_LO) |-> pos_in_store)
    else $error("record value read beyond the store");

  // Sending the end result returns the sequencer to idle.
  a_end_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && ld_last) |=> state_q == kmlp_pkg::S_IDLE)
    else $error("end result sent without returning to idle");

  // Pops and pushes never coincide.
  a_stack_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(held_req_o.push && held_req_o.pop))
    else $error("push and pop in the same cycle");

endmodule

`default_nettype wire

### sv/key_macro_list_player_core.sv
// ----------------------------------------------------------------------------
// key_macro_list_player_core: key macro list player
// Byte store of macro records with write, read, play and release items.
// ----------------------------------------------------------------------------
// A write, a read or a release ends with an end result; a release first sends
// one event per held key. A play walks the store through its single read port
// and the shared position adder, skipping lone bytes or whole records before
// the selected macro, then playing its records. One item at a time: input
// stalls until the end result is loaded. Reset restores opcode defaults,
// empties the held stack and clears the store's written flags, so every byte
// reads 0xFF at once.
`default_nettype none

module key_macro_list_player_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [7:0]  addr_i,
  input  wire logic [7:0]  byte_data_i,
  input  wire logic [7:0]  macro_number_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       event_kind_o,
  output logic [15:0]      event_value_o,
  output logic             last_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  kmlp_pkg::opcodes_t   ops_q, ops_d;
  kmlp_pkg::store_req_t store_req;
  logic [7:0]           store_rdata;
  kmlp_pkg::held_req_t  held_req;
  kmlp_pkg::held_stat_t held_stat;

  // Configuration writes are always taken; unknown indexes are ignored.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    ops_d = ops_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        kmlp_pkg::CFG_IDX_END:   ops_d.end_op   = cfg_data_i;
        kmlp_pkg::CFG_IDX_TAP:   ops_d.tap_op   = cfg_data_i;
        kmlp_pkg::CFG_IDX_PRESS: ops_d.press_op = cfg_data_i;
        kmlp_pkg::CFG_IDX_DELAY: ops_d.delay_op = cfg_data_i;
        default: ops_d = ops_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ops_q.end_op   <= 8'd0;
      ops_q.tap_op   <= 8'd1;
      ops_q.press_op <= 8'd2;
      ops_q.delay_op <= 8'd3;
    end else begin
      ops_q <= ops_d;
    end
  end

  kmlp_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (store_req),
    .rdata_o (store_rdata)
  );

  kmlp_held u_held (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (held_req),
    .stat_o (held_stat)
  );

  kmlp_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ops_i          (ops_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .addr_i         (addr_i),
    .byte_data_i    (byte_data_i),
    .macro_number_i (macro_number_i),
    .store_req_o    (store_req),
    .store_rdata_i  (store_rdata),
    .held_req_o     (held_req),
    .held_stat_i    (held_stat),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_kind_o   (event_kind_o),
    .event_value_o  (event_value_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire
